// ----- hdl/wsd_pkg.sv -----
// Shared types and constants for the WebSocket client frame deframer.
// No dependencies; imported by the parser, output stage, top level, checker and testbench.
package wsd_pkg;

  localparam int unsigned CapW = 25;

  localparam logic [CapW-1:0] CAP_RESET = 25'd16777216;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_UNMASKED = 2'd1;
  localparam logic [1:0] ERR_TOO_LONG = 2'd2;

  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  // One result word from the parser to the output register
  typedef struct packed {
    logic       vld;
    logic [7:0] payload_byte;
    logic       has_byte;
    logic       frame_end;
    logic [3:0] frame_opcode;
    logic       final_fragment;
    logic [1:0] error_code;
  } wsd_result_t;

endpackage

// ----- hdl/wsd_parser.sv -----
// Frame header / key / payload sequencer of the deframer.
// Depends on wsd_pkg; produces at most one result word per accepted byte.
module wsd_parser (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      accept,
  input  logic [7:0]                stream_byte,
  input  logic [wsd_pkg::CapW-1:0]  cap,
  output wsd_pkg::wsd_result_t      res
);
  import wsd_pkg::*;

  localparam logic [2:0] PH_HDR0    = 3'd0;
  localparam logic [2:0] PH_HDR1    = 3'd1;
  localparam logic [2:0] PH_EXTLEN  = 3'd2;
  localparam logic [2:0] PH_KEY     = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_HALTED  = 3'd5;

  logic [2:0]      phase_r, phase_nxt;
  logic [2:0]      left_r, left_nxt;
  logic [CapW-1:0] len_r, len_nxt;
  logic            len_hi_r, len_hi_nxt;
  logic [31:0]     key_r, key_nxt;
  logic [3:0]      opcode_r, opcode_nxt;
  logic            fin_r, fin_nxt;

  logic [CapW-1:0] len_shift;
  logic            len_hi_shift;

  // Shift one extended-length byte in; remember any bits pushed out the top
  assign len_shift    = {len_r[CapW-9:0], stream_byte};
  assign len_hi_shift = len_hi_r | (|len_r[CapW-1:CapW-8]);

  // Next state and result for the byte on the input
  always_comb begin
    phase_nxt  = phase_r;
    left_nxt   = left_r;
    len_nxt    = len_r;
    len_hi_nxt = len_hi_r;
    key_nxt    = key_r;
    opcode_nxt = opcode_r;
    fin_nxt    = fin_r;

    res                = '0;
    res.frame_opcode   = opcode_r;
    res.final_fragment = fin_r;

    case (phase_r)
      PH_HDR0: begin
        fin_nxt    = stream_byte[7];
        opcode_nxt = stream_byte[3:0];
        phase_nxt  = PH_HDR1;
      end
      PH_HDR1: begin
        len_hi_nxt = 1'b0;
        if (!stream_byte[7]) begin
          res.vld        = 1'b1;
          res.error_code = ERR_UNMASKED;
          phase_nxt      = PH_HALTED;
        end else if (stream_byte[6:0] == LEN7_EXT16) begin
          len_nxt   = '0;
          left_nxt  = 3'd1;
          phase_nxt = PH_EXTLEN;
        end else if (stream_byte[6:0] == LEN7_EXT64) begin
          len_nxt   = '0;
          left_nxt  = 3'd7;
          phase_nxt = PH_EXTLEN;
        end else begin
          len_nxt = {{(CapW-7){1'b0}}, stream_byte[6:0]};
          if ({{(CapW-7){1'b0}}, stream_byte[6:0]} > cap) begin
            res.vld        = 1'b1;
            res.error_code = ERR_TOO_LONG;
            phase_nxt      = PH_HALTED;
          end else begin
            left_nxt  = 3'd3;
            phase_nxt = PH_KEY;
          end
        end
      end
      PH_EXTLEN: begin
        len_nxt    = len_shift;
        len_hi_nxt = len_hi_shift;
        if (left_r == 3'd0) begin
          if (len_hi_shift || (len_shift > cap)) begin
            res.vld        = 1'b1;
            res.error_code = ERR_TOO_LONG;
            phase_nxt      = PH_HALTED;
          end else begin
            left_nxt  = 3'd3;
            phase_nxt = PH_KEY;
          end
        end else begin
          left_nxt = left_r - 3'd1;
        end
      end
      PH_KEY: begin
        key_nxt = {key_r[23:0], stream_byte};
        if (left_r != 3'd0) begin
          left_nxt = left_r - 3'd1;
        end else if (len_r == '0) begin
          // Empty frame: one marker word
          res.vld       = 1'b1;
          res.frame_end = 1'b1;
          phase_nxt     = PH_HDR0;
        end else begin
          phase_nxt = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        // Unmask with the leading key byte, then rotate the key and count down
        res.vld          = 1'b1;
        res.has_byte     = 1'b1;
        res.payload_byte = stream_byte ^ key_r[31:24];
        res.frame_end    = (len_r == {{(CapW-1){1'b0}}, 1'b1});
        key_nxt          = {key_r[23:0], key_r[31:24]};
        len_nxt          = len_r - {{(CapW-1){1'b0}}, 1'b1};
        if (res.frame_end) begin
          phase_nxt = PH_HDR0;
        end
      end
      PH_HALTED: begin
        // Drop every byte until reset
      end
      default: begin
        phase_nxt = PH_HALTED;
      end
    endcase

    if (!accept) begin
      res.vld = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR0;
      left_r  <= 3'd0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
    end
  end

  // Frame context
  always_ff @(posedge clk) begin
    if (accept) begin
      len_r    <= len_nxt;
      len_hi_r <= len_hi_nxt;
      key_r    <= key_nxt;
      opcode_r <= opcode_nxt;
      fin_r    <= fin_nxt;
    end
  end

endmodule

// ----- hdl/wsd_out_reg.sv -----
// Result register of the deframer: holds one word while the receiver stalls.
// Depends on wsd_pkg for the result word type.
module wsd_out_reg (
  input  logic                  clk,
  input  logic                  rst_n,
  input  wsd_pkg::wsd_result_t  res,
  input  logic                  out_stall,
  output logic                  full_stalled,
  output logic                  out_valid,
  output wsd_pkg::wsd_result_t  out_word
);
  import wsd_pkg::*;

  logic        valid_r, valid_nxt;
  wsd_result_t word_r;

  // Hold while stalled, else take whatever the parser produced this cycle
  assign full_stalled = valid_r & out_stall;
  assign valid_nxt    = full_stalled | res.vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!full_stalled && res.vld) begin
      word_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;

endmodule

// ----- hdl/websocket_client_frame_deframer.sv -----
// Top level of the WebSocket client-to-server frame deframer.
// Depends on wsd_pkg, wsd_parser and wsd_out_reg.
//
// Usage:
//   Input channel (in_valid / in_stall / in_stream_byte) carries the raw
//   client stream, one byte per word. Output channel (out_valid / out_stall
//   and the out_ fields) carries at most one result word per input byte:
//   an unmasked payload byte, an empty-frame marker, or an error word.
//   The cfg_ write channel sets the 25-bit payload length cap; cfg_ready is
//   always high. The user must write the cap only while the block is idle;
//   the block does not enforce it. A result word is registered and appears
//   on the output in the cycle after its byte is accepted. Throughput: one
//   byte per cycle unless stalled, set by the single header/key/payload
//   sequencer that updates its state every byte. The result register lets a
//   new byte in while the previous word is being taken; in_stall rises only
//   when that register is full and the receiver stalls; the held word stays
//   unchanged. After an error word the block drops every byte until reset.
//   Reset (rst_n low, synchronous) returns the parser to the first header
//   byte, empties the result register and restores the cap to 16 MiB.
module websocket_client_frame_deframer (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [7:0]               in_stream_byte,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [7:0]               out_payload_byte,
  output logic                     out_has_byte,
  output logic                     out_frame_end,
  output logic [3:0]               out_frame_opcode,
  output logic                     out_final_fragment,
  output logic [1:0]               out_error_code,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [wsd_pkg::CapW-1:0] cfg_data
);
  import wsd_pkg::*;

  logic            accept;
  logic            full_stalled;
  logic [CapW-1:0] cap_r;
  wsd_result_t     res;
  wsd_result_t     out_word;

  // Length cap register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cap_r <= cfg_data;
    end
  end

  // Take a byte whenever the result register can accept a word
  assign in_stall = full_stalled;
  assign accept   = in_valid & ~full_stalled;

  wsd_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .stream_byte (in_stream_byte),
    .cap         (cap_r),
    .res         (res)
  );

  wsd_out_reg u_out_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .res          (res),
    .out_stall    (out_stall),
    .full_stalled (full_stalled),
    .out_valid    (out_valid),
    .out_word     (out_word)
  );

  assign out_payload_byte   = out_word.payload_byte;
  assign out_has_byte       = out_word.has_byte;
  assign out_frame_end      = out_word.frame_end;
  assign out_frame_opcode   = out_word.frame_opcode;
  assign out_final_fragment = out_word.final_fragment;
  assign out_error_code     = out_word.error_code;

endmodule

// ----- hdl/wsd_checker.sv -----
// Port-level checks for the deframer, bound to the top level.
// Depends on wsd_pkg for the error codes.
module wsd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_payload_byte,
  input logic       out_has_byte,
  input logic       out_frame_end,
  input logic [3:0] out_frame_opcode,
  input logic       out_final_fragment,
  input logic [1:0] out_error_code
);
  import wsd_pkg::*;

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_payload_byte)
      && $stable(out_has_byte) && $stable(out_frame_end)
      && $stable(out_frame_opcode) && $stable(out_final_fragment)
      && $stable(out_error_code))
    else $error("stalled result word changed");

  // Error words carry no byte and close no frame
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_error_code != ERR_NONE) |-> !out_has_byte && !out_frame_end)
    else $error("error word carries data or frame end");

  // A word without data and without error is an empty-frame marker
  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_byte && (out_error_code == ERR_NONE) |-> out_frame_end)
    else $error("data-less word is neither marker nor error");

  // Data-less words show a zero byte
  a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_byte |-> out_payload_byte == 8'd0)
    else $error("nonzero byte on a data-less word");

  // Halt after a delivered error word
  a_halt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && (out_error_code != ERR_NONE) |=> !out_valid)
    else $error("result after an error word");

endmodule

bind websocket_client_frame_deframer wsd_checker u_wsd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_payload_byte   (out_payload_byte),
  .out_has_byte       (out_has_byte),
  .out_frame_end      (out_frame_end),
  .out_frame_opcode   (out_frame_opcode),
  .out_final_fragment (out_final_fragment),
  .out_error_code     (out_error_code)
);

// ----- tb/testbench.sv -----
// Self-checking testbench for the WebSocket client frame deframer.
// Depends on wsd_pkg and websocket_client_frame_deframer; drives directed and random
// frames, predicts each result word and compares it with the output channel.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import wsd_pkg::*;

  localparam int HALF_PERIOD  = 4;
  localparam int RESET_CYCLES = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_BYTES  = 210;
  localparam int SETTLE_CYCLES = 4;
  localparam int LIMIT_CYCLES = 500000;
  localparam int PRINT_LIMIT  = 100;

  localparam logic [3:0] OP_CONT    = 4'h0;
  localparam logic [3:0] OP_TEXT    = 4'h1;
  localparam logic [3:0] OP_BIN     = 4'h2;
  localparam logic [3:0] OP_CLOSE   = 4'h8;
  localparam logic [3:0] OP_PING    = 4'h9;
  localparam logic [3:0] OP_PONG    = 4'hA;
  localparam logic [3:0] OP_UNKNOWN = 4'hF;
  localparam logic [3:0] KNOWN_OPS [6] = '{OP_CONT, OP_TEXT, OP_BIN, OP_CLOSE, OP_PING, OP_PONG};

  localparam logic [CapW-1:0] CAP_FULL = '1;

  typedef enum logic [2:0] {
    PH_HDR0, PH_HDR1, PH_EXTLEN, PH_KEY, PH_PAYLOAD, PH_HALTED
  } parse_phase_e;

  typedef enum logic [1:0] {ROW_MODEL, ROW_QUIET, ROW_WORD} row_kind_e;
  typedef enum int {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_e;
  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_e;
  typedef enum int {END_UNMASKED, END_OVER_CAP, END_TOP_BIT, END_NOISE} end_kind_e;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       frame_end;
    logic [3:0] opcode;
    logic       fin;
    logic [1:0] err;
  } rx_word_t;

  typedef struct packed {
    row_kind_e  kind;
    logic [7:0] data;
    rx_word_t   word;
  } stim_row_t;

  localparam rx_word_t NO_WORD = '0;

  // Directed frames: masked text with two bytes, empty ping, unknown opcode
  // with a non-minimal 16-bit length and no FIN
  stim_row_t directed [25] = '{
    '{ROW_QUIET, {1'b1, 3'b000, OP_TEXT}, NO_WORD},
    '{ROW_QUIET, {1'b1, 7'd2}, NO_WORD},
    '{ROW_QUIET, 8'h11, NO_WORD},
    '{ROW_QUIET, 8'h22, NO_WORD},
    '{ROW_QUIET, 8'h33, NO_WORD},
    '{ROW_QUIET, 8'h44, NO_WORD},
    '{ROW_WORD, 8'h00, '{8'h11, 1'b1, 1'b0, OP_TEXT, 1'b1, ERR_NONE}},
    '{ROW_WORD, 8'hFF, '{8'hDD, 1'b1, 1'b1, OP_TEXT, 1'b1, ERR_NONE}},
    '{ROW_QUIET, {1'b1, 3'b000, OP_PING}, NO_WORD},
    '{ROW_QUIET, {1'b1, 7'd0}, NO_WORD},
    '{ROW_QUIET, 8'hAA, NO_WORD},
    '{ROW_QUIET, 8'hBB, NO_WORD},
    '{ROW_QUIET, 8'hCC, NO_WORD},
    '{ROW_WORD, 8'hDD, '{8'h00, 1'b0, 1'b1, OP_PING, 1'b1, ERR_NONE}},
    '{ROW_MODEL, {1'b0, 3'b111, OP_UNKNOWN}, NO_WORD},
    '{ROW_MODEL, {1'b1, LEN7_EXT16}, NO_WORD},
    '{ROW_MODEL, 8'h00, NO_WORD},
    '{ROW_MODEL, 8'h03, NO_WORD},
    '{ROW_MODEL, 8'hFF, NO_WORD},
    '{ROW_MODEL, 8'h00, NO_WORD},
    '{ROW_MODEL, 8'h5A, NO_WORD},
    '{ROW_MODEL, 8'hA5, NO_WORD},
    '{ROW_MODEL, 8'hFF, NO_WORD},
    '{ROW_MODEL, 8'h00, NO_WORD},
    '{ROW_MODEL, 8'h80, NO_WORD}
  };

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_stall;
  logic [7:0]      in_stream_byte;
  logic            out_valid;
  logic            out_stall;
  logic [7:0]      out_payload_byte;
  logic            out_has_byte;
  logic            out_frame_end;
  logic [3:0]      out_frame_opcode;
  logic            out_final_fragment;
  logic [1:0]      out_error_code;
  logic            cfg_valid;
  logic            cfg_ready;
  logic [CapW-1:0] cfg_data;

  // Tags that travel with the byte on the input channel
  row_kind_e row_kind;
  rx_word_t  row_word;

  // Parser state as predicted
  parse_phase_e    ph_q   = PH_HDR0;
  logic [2:0]      left_q = '0;
  logic [63:0]     len_q  = '0;
  logic [31:0]     key_q  = '0;
  logic [CapW-1:0] idx_q  = '0;
  logic [3:0]      opc_q  = '0;
  logic            fin_q  = 1'b0;
  logic [CapW-1:0] cap_q  = CAP_RESET;

  rx_word_t pending_words [$];
  int       mismatches  = 0;
  int       sent_bytes  = 0;
  int       burst_left  = 0;
  int       cycle_count = 0;
  bit       hold_req    = 1'b0;
  bit       hold_done   = 1'b0;

  websocket_client_frame_deframer dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_stream_byte     (in_stream_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_payload_byte   (out_payload_byte),
    .out_has_byte       (out_has_byte),
    .out_frame_end      (out_frame_end),
    .out_frame_opcode   (out_frame_opcode),
    .out_final_fragment (out_final_fragment),
    .out_error_code     (out_error_code),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data)
  );

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  // Halt the parser and build the error word for this frame
  function automatic rx_word_t halt_word(input logic [1:0] code);
    ph_q = PH_HALTED;
    return '{8'h00, 1'b0, 1'b0, opc_q, fin_q, code};
  endfunction

  // Length complete: reject it above the cap, else expect the key
  function automatic bit check_length(output rx_word_t w);
    w = NO_WORD;
    if (len_q > 64'(cap_q)) begin
      w = halt_word(ERR_TOO_LONG);
      return 1'b1;
    end
    ph_q = PH_KEY;
    left_q = 3'd3;
    key_q = '0;
    return 1'b0;
  endfunction

  // Advance the predicted parser by one stream byte; returns 1 with a word
  function automatic bit deframe_byte(input logic [7:0] b, output rx_word_t w);
    logic [7:0] k;
    w = NO_WORD;
    case (ph_q)
      PH_HDR0: begin
        fin_q = b[7];
        opc_q = b[3:0];
        ph_q = PH_HDR1;
        return 1'b0;
      end
      PH_HDR1: begin
        if (!b[7]) begin
          w = halt_word(ERR_UNMASKED);
          return 1'b1;
        end
        len_q = '0;
        if (b[6:0] == LEN7_EXT16) begin
          ph_q = PH_EXTLEN;
          left_q = 3'd1;
          return 1'b0;
        end
        if (b[6:0] == LEN7_EXT64) begin
          ph_q = PH_EXTLEN;
          left_q = 3'd7;
          return 1'b0;
        end
        len_q = 64'(b[6:0]);
        return check_length(w);
      end
      PH_EXTLEN: begin
        len_q = {len_q[55:0], b};
        if (left_q == 3'd0) return check_length(w);
        left_q = left_q - 3'd1;
        return 1'b0;
      end
      PH_KEY: begin
        key_q = {key_q[23:0], b};
        if (left_q != 3'd0) begin
          left_q = left_q - 3'd1;
          return 1'b0;
        end
        idx_q = '0;
        if (len_q == 64'd0) begin
          ph_q = PH_HDR0;
          w = '{8'h00, 1'b0, 1'b1, opc_q, fin_q, ERR_NONE};
          return 1'b1;
        end
        ph_q = PH_PAYLOAD;
        return 1'b0;
      end
      PH_PAYLOAD: begin
        // key bytes go out most significant first
        k = 8'(key_q >> (8 * (3 - int'(idx_q[1:0]))));
        idx_q = idx_q + 1'b1;
        w = '{b ^ k, 1'b1, 1'b0, opc_q, fin_q, ERR_NONE};
        w.frame_end = (64'(idx_q) >= len_q);
        if (w.frame_end) ph_q = PH_HDR0;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < PRINT_LIMIT)
      $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
    mismatches++;
  endtask

  // Score the output, then predict the byte taken at this edge
  always @(posedge clk) begin : monitor
    rx_word_t w;
    rx_word_t want;
    bit       got;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_words.size() == 0) begin
          report_mismatch("result word with none pending", out_payload_byte, 0);
        end else begin
          want = pending_words.pop_front();
          if (out_payload_byte !== want.data)
            report_mismatch("payload_byte", out_payload_byte, want.data);
          if (out_has_byte !== want.has_byte)
            report_mismatch("has_byte", out_has_byte, want.has_byte);
          if (out_frame_end !== want.frame_end)
            report_mismatch("frame_end", out_frame_end, want.frame_end);
          if (out_frame_opcode !== want.opcode)
            report_mismatch("frame_opcode", out_frame_opcode, want.opcode);
          if (out_final_fragment !== want.fin)
            report_mismatch("final_fragment", out_final_fragment, want.fin);
          if (out_error_code !== want.err)
            report_mismatch("error_code", out_error_code, want.err);
        end
      end
      if (in_valid && !in_stall) begin
        got = deframe_byte(in_stream_byte, w);
        case (row_kind)
          ROW_WORD:  pending_words.insert(pending_words.size(), row_word);
          ROW_QUIET: ;
          default: begin
            if (got) pending_words.insert(pending_words.size(), w);
          end
        endcase
      end
      if (cfg_valid && cfg_ready) cap_q = cfg_data;
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: stall on changing patterns, with one long hold-off on request
  initial begin : receiver
    rx_mode_e mode;
    int       run;
    int       tick;
    int       held;
    mode = RX_FREE;
    run = 0;
    tick = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        held = 1;
        while (held < HOLD_CYCLES) begin
          @(negedge clk);
          held++;
        end
        hold_done = 1'b1;
      end else begin
        if (run == 0) begin
          mode = rx_mode_e'($urandom_range(0, 3));
          run = $urandom_range(16, 160);
        end
        run--;
        tick++;
        case (mode)
          RX_FREE:  out_stall <= 1'b0;
          RX_LIGHT: out_stall <= ($urandom_range(0, 99) < 30);
          RX_HEAVY: out_stall <= ($urandom_range(0, 99) < 75);
          default:  out_stall <= (tick % 4 == 3);
        endcase
      end
    end
  end

  // Offer one word, in bursts with random gaps, and hold it until taken
  task automatic send_byte(input logic [7:0] b, input row_kind_e k, input rx_word_t w);
    int gap;
    int r;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      r = $urandom_range(0, 9);
      if (r >= 8) gap = $urandom_range(4, 20);
      else if (r >= 4) gap = $urandom_range(1, 3);
    end
    burst_left--;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_stream_byte <= b;
    row_kind <= k;
    row_word <= w;
    do @(posedge clk); while (in_stall);
    sent_bytes++;
  endtask

  // Drop valid and wait until every pending word has come out
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_cap(input logic [CapW-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_frame(input logic [3:0] op, input logic fin, input int unsigned len,
                            input len_form_e form);
    logic [7:0] fb [$];
    fb.insert(fb.size(), {fin, 3'($urandom_range(0, 7)), op});
    case (form)
      LEN_SHORT: fb.insert(fb.size(), {1'b1, 7'(len)});
      LEN_EXT16: begin
        fb.insert(fb.size(), {1'b1, LEN7_EXT16});
        fb.insert(fb.size(), len[15:8]);
        fb.insert(fb.size(), len[7:0]);
      end
      default: begin
        fb.insert(fb.size(), {1'b1, LEN7_EXT64});
        repeat (6) fb.insert(fb.size(), 8'h00);
        fb.insert(fb.size(), len[15:8]);
        fb.insert(fb.size(), len[7:0]);
      end
    endcase
    repeat (4 + len) fb.insert(fb.size(), 8'($urandom));
    foreach (fb[i]) send_byte(fb[i], ROW_MODEL, NO_WORD);
  endtask

  // Random well-formed frames that fit the cap, then drain
  task automatic run_phase(input bit do_write, input logic [CapW-1:0] cap_v, input int budget);
    int          start;
    int unsigned maxl;
    int unsigned len;
    len_form_e   form;
    logic [3:0]  op;
    if (do_write) write_cap(cap_v);
    start = sent_bytes;
    while (sent_bytes - start < budget) begin
      if ($urandom_range(0, 9) < 8) op = KNOWN_OPS[$urandom_range(0, 5)];
      else op = 4'($urandom_range(0, 15));
      if (cap_v < 48) maxl = cap_v;
      else if ($urandom_range(0, 9) == 0) maxl = (cap_v < 300) ? cap_v : 300;
      else maxl = 48;
      len = $urandom_range(0, maxl);
      if (cap_v <= 300 && $urandom_range(0, 4) == 0) len = cap_v;
      if (len > 125) form = len_form_e'($urandom_range(1, 2));
      else form = len_form_e'($urandom_range(0, 2));
      send_frame(op, 1'($urandom_range(0, 1)), len, form);
    end
    settle();
  endtask

  initial begin : stimulus
    end_kind_e  kind;
    int         cap_v;
    logic [7:0] tail [$];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_stream_byte = '0;
    row_kind = ROW_MODEL;
    row_word = NO_WORD;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed frames at the reset cap
    foreach (directed[i]) send_byte(directed[i].data, directed[i].kind, directed[i].word);
    settle();

    // Random phases over several caps; the first one backs up the output
    hold_req = 1'b1;
    run_phase(1'b0, CAP_RESET, PHASE_BYTES);
    run_phase(1'b1, '0, PHASE_BYTES);
    run_phase(1'b1, 25'd1, PHASE_BYTES);
    run_phase(1'b1, 25'd125, PHASE_BYTES);
    run_phase(1'b1, 25'd126, PHASE_BYTES);
    run_phase(1'b1, CAP_FULL, PHASE_BYTES);
    run_phase(1'b1, 25'($urandom_range(0, int'(CAP_FULL))), PHASE_BYTES);
    run_phase(1'b1, CAP_RESET, PHASE_BYTES);

    // End of run: one frame that halts the parser (none for END_NOISE), then random bytes
    kind = end_kind_e'($urandom_range(0, 3));
    cap_v = 0;
    if (kind == END_OVER_CAP) begin
      cap_v = $urandom_range(0, 124);
      write_cap(25'(cap_v));
    end
    case (kind)
      END_UNMASKED: begin
        tail.insert(tail.size(), 8'($urandom));
        tail.insert(tail.size(), {1'b0, 7'($urandom)});
      end
      END_OVER_CAP: begin
        tail.insert(tail.size(), 8'($urandom));
        tail.insert(tail.size(), {1'b1, 7'($urandom_range(cap_v + 1, 125))});
      end
      END_TOP_BIT: begin
        tail.insert(tail.size(), 8'($urandom));
        tail.insert(tail.size(), {1'b1, LEN7_EXT64});
        tail.insert(tail.size(), 8'($urandom) | 8'h80);
        repeat (7) tail.insert(tail.size(), 8'($urandom));
      end
      default: ;
    endcase
    repeat (60) tail.insert(tail.size(), 8'($urandom));
    foreach (tail[i]) send_byte(tail[i], ROW_MODEL, NO_WORD);
    settle();

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/wsd_pkg.sv
hdl/wsd_parser.sv
hdl/wsd_out_reg.sv
hdl/websocket_client_frame_deframer.sv
hdl/wsd_checker.sv
tb/testbench.sv
